/* rtl/core/bscp_pkg.sv */
// Shared types and constants of the bounded sorted candidate pool.
package bscp_pkg;

   localparam int CSR_DATA_BITS = 21;
   localparam int WORD_BITS     = 32;
   localparam int BIT_SEL_BITS  = 5;

   localparam logic [0:0] CSR_POOL_LIMIT = 1'b0;
   localparam logic [0:0] CSR_NODE_COUNT = 1'b1;

   localparam logic [7:0]  POOL_MIN       = 8'd10;
   localparam logic [7:0]  POOL_LIMIT_RST = 8'd100;
   localparam logic [20:0] NODE_COUNT_RST = 21'h100000;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_OFFER = 2'd1,
      MODE_TAKE  = 2'd2,
      MODE_READ  = 2'd3
   } bscp_mode_type;

   typedef enum logic [2:0] {
      STS_OK      = 3'd0,
      STS_SEEN    = 3'd1,
      STS_RANGE   = 3'd2,
      STS_DROPPED = 3'd3,
      STS_NONE    = 3'd4,
      STS_EMPTY   = 3'd5,
      STS_CLEARED = 3'd6
   } bscp_status_type;

   typedef enum logic [1:0] {
      S_CLEAR = 2'd0,
      S_IDLE  = 2'd1,
      S_EXEC  = 2'd2
   } bscp_state_type;

   typedef struct packed {
      logic ins;
      logic mark;
   } bscp_cell_ctl_type;

endpackage

/* rtl/core/bscp_visit_mem.sv */
// Visited bitmap storage, one 32-bit row per address, registered read.
module bscp_visit_mem #(
   parameter int ROW_BITS = 15
) (
   input  logic                            clock,
   input  logic [ROW_BITS-1:0]             rd_addr,
   output logic [bscp_pkg::WORD_BITS-1:0]  rd_data,
   input  logic                            wr_en,
   input  logic [ROW_BITS-1:0]             wr_addr,
   input  logic [bscp_pkg::WORD_BITS-1:0]  wr_data
);
   import bscp_pkg::*;

   logic [WORD_BITS-1:0] mem [2**ROW_BITS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/core/bscp_cell.sv */
// One list cell: holds an entry; on insert shifts, takes the new entry or keeps; on take marks it expanded.
module bscp_cell #(
   parameter int INDEX     = 0,
   parameter int NODE_BITS = 20,
   parameter int FILL_BITS = 8
) (
   input  logic                         clock,
   input  bscp_pkg::bscp_cell_ctl_type  ctl,
   input  logic [FILL_BITS-1:0]         fill,
   input  logic [NODE_BITS-1:0]         new_node,
   input  logic signed [31:0]           new_dist,
   input  logic [NODE_BITS-1:0]         left_node,
   input  logic signed [31:0]           left_dist,
   input  logic                         left_exp,
   input  logic                         left_before,
   output logic [NODE_BITS-1:0]         node,
   output logic signed [31:0]           distance,
   output logic                         exp,
   output logic                         valid,
   output logic                         ahead,
   output logic                         cand
);
   import bscp_pkg::*;

   logic [NODE_BITS-1:0] node_ff;
   logic signed [31:0]   dist_ff;
   logic                 exp_ff;

   assign valid    = FILL_BITS'(INDEX) < fill;
   assign ahead    = valid && ((dist_ff < new_dist) ||
                               ((dist_ff == new_dist) && (node_ff < new_node)));
   assign cand     = valid && !exp_ff;
   assign node     = node_ff;
   assign distance = dist_ff;
   assign exp      = exp_ff;

   always_ff @(posedge clock) begin
      if (ctl.ins) begin
         if (!left_before) begin
            node_ff <= left_node;
            dist_ff <= left_dist;
            exp_ff  <= left_exp;
         end else if (!ahead) begin
            node_ff <= new_node;
            dist_ff <= new_dist;
            exp_ff  <= 1'b0;
         end
      end else if (ctl.mark) begin
         exp_ff <= 1'b1;
      end
   end

endmodule

/* rtl/core/bounded_sorted_candidate_pool.sv */
// Top level of the bounded sorted candidate pool: control, cell chain, bitmap.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | mode, node_id, distance, slot
//  rsp     | out       | rsp_valid/rsp_stall | status, result_node, result_distance,
//          |           |                     | result_expanded, entry_count
//  csr     | in        | csr_wr_en           | csr_index, csr_wdata
//
// Offer, take and read: the accept cycle reads the bitmap row, and the execute
// state then updates the cell chain and loads the response register.
// Clear sweeps every bitmap row, one row per cycle, then executes and responds.
// After reset the same sweep runs before the first transaction is taken.
// A stalled response holds the block in its execute cycle.
module bounded_sorted_candidate_pool #(
   parameter int LIST_DEPTH = 128,
   parameter int NODE_BITS  = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_mode,
   input  logic [31:0]                          req_node_id,
   input  logic signed [31:0]                   req_distance,
   input  logic [6:0]                           req_slot,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [2:0]                           rsp_status,
   output logic [NODE_BITS-1:0]                 rsp_result_node,
   output logic signed [31:0]                   rsp_result_distance,
   output logic                                 rsp_result_expanded,
   output logic [7:0]                           rsp_entry_count,
   input  logic                                 csr_wr_en,
   input  logic [0:0]                           csr_index,
   input  logic [bscp_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import bscp_pkg::*;

   localparam int ROW_BITS  = NODE_BITS - BIT_SEL_BITS;
   localparam int FILL_BITS = $clog2(LIST_DEPTH + 1);
   localparam int CMP_BITS  = (FILL_BITS + 1 > 9) ? FILL_BITS + 1 : 9;
   localparam int GRP       = 8;
   localparam int NGRP      = (LIST_DEPTH + GRP - 1) / GRP;
   localparam int PAD       = NGRP * GRP;

   bscp_state_type       state_ff, state_in;
   logic [ROW_BITS-1:0]  clr_cnt_ff, clr_cnt_in;
   logic                 pend_ff, pend_in;
   logic                 accept;
   logic                 exec_fire;

   bscp_mode_type        mode_ff;
   logic [31:0]          node_ff;
   logic signed [31:0]   dist_ff;
   logic [6:0]           slot_ff;

   logic [7:0]                 pool_limit_ff;
   logic [CSR_DATA_BITS-1:0]   node_count_ff;
   logic [FILL_BITS-1:0]       fill_ff, fill_in;

   logic                       rsp_valid_ff;
   bscp_status_type            rsp_status_ff, rsp_status_in;
   logic [NODE_BITS-1:0]       rsp_node_ff, rsp_node_in;
   logic signed [31:0]         rsp_dist_ff, rsp_dist_in;
   logic                       rsp_exp_ff, rsp_exp_in;
   logic [7:0]                 rsp_count_ff;

   logic [ROW_BITS-1:0]   mem_rd_addr, mem_wr_addr;
   logic [WORD_BITS-1:0]  mem_rd_data, mem_wr_data;
   logic                  mem_wr_en;

   logic [NODE_BITS-1:0]  c_node [LIST_DEPTH];
   logic signed [31:0]    c_dist [LIST_DEPTH];
   logic [LIST_DEPTH-1:0] c_exp, c_valid, c_before, c_cand;
   logic [LIST_DEPTH-1:0] take_sel, rd_sel, out_sel;
   logic [PAD-1:0]        cand_pad, take_pad;
   logic [NGRP-1:0]       grp_any_in, grp_any_ff, grp_first;
   bscp_cell_ctl_type     cell_ctl [LIST_DEPTH];

   logic [NODE_BITS-1:0]  new_node;
   logic                  out_range, seen, fresh, all_before, drop, can_grow;
   logic                  slot_ok, any_cand;
   logic [CMP_BITS-1:0]   lim, pl_ext, fill_ext, fill_in_ext;
   logic [NODE_BITS-1:0]  sel_node;
   logic signed [31:0]    sel_dist;
   logic                  sel_exp;

   // control state machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         pend_ff    <= pend_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      pend_in    = pend_ff;
      accept     = 1'b0;
      exec_fire  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff) begin
               state_in = pend_ff ? S_EXEC : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               accept = 1'b1;
               if (bscp_mode_type'(req_mode) == MODE_CLEAR) begin
                  state_in = S_CLEAR;
                  pend_in  = 1'b1;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               exec_fire = 1'b1;
               pend_in   = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= bscp_mode_type'(req_mode);
         node_ff <= req_node_id;
         dist_ff <= req_distance;
         slot_ff <= req_slot;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_limit_ff <= POOL_LIMIT_RST;
         node_count_ff <= NODE_COUNT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_POOL_LIMIT: pool_limit_ff <= csr_wdata[7:0];
            CSR_NODE_COUNT: node_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // visited bitmap
   assign mem_rd_addr = (state_ff == S_IDLE) ? req_node_id[NODE_BITS-1:BIT_SEL_BITS]
                                             : node_ff[NODE_BITS-1:BIT_SEL_BITS];
   assign mem_wr_en   = (state_ff == S_CLEAR) || (exec_fire && mode_ff == MODE_OFFER && fresh);
   assign mem_wr_addr = (state_ff == S_CLEAR) ? clr_cnt_ff
                                              : node_ff[NODE_BITS-1:BIT_SEL_BITS];
   assign mem_wr_data = (state_ff == S_CLEAR) ? '0
                        : (mem_rd_data | (32'd1 << node_ff[BIT_SEL_BITS-1:0]));

   bscp_visit_mem #(
      .ROW_BITS (ROW_BITS)
   ) u_visit (
      .clock   (clock),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   assign out_range = (node_ff >= {11'd0, node_count_ff}) || ((node_ff >> NODE_BITS) != 32'd0);
   assign seen      = mem_rd_data[node_ff[BIT_SEL_BITS-1:0]];
   assign fresh     = !out_range && !seen;
   assign new_node  = node_ff[NODE_BITS-1:0];

   // cell chain
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic [NODE_BITS-1:0] l_node;
      logic signed [31:0]   l_dist;
      logic                 l_exp;
      logic                 l_before;
      if (i == 0) begin : g_head
         assign l_node   = new_node;
         assign l_dist   = dist_ff;
         assign l_exp    = 1'b0;
         assign l_before = 1'b1;
      end else begin : g_link
         assign l_node   = c_node[i-1];
         assign l_dist   = c_dist[i-1];
         assign l_exp    = c_exp[i-1];
         assign l_before = c_before[i-1];
      end
      assign cell_ctl[i].ins  = exec_fire && mode_ff == MODE_OFFER && fresh && !drop;
      assign cell_ctl[i].mark = exec_fire && mode_ff == MODE_TAKE && take_sel[i];
      assign rd_sel[i] = slot_ok && (CMP_BITS'(slot_ff) == CMP_BITS'(i));

      bscp_cell #(
         .INDEX     (i),
         .NODE_BITS (NODE_BITS),
         .FILL_BITS (FILL_BITS)
      ) u_cell (
         .clock       (clock),
         .ctl         (cell_ctl[i]),
         .fill        (fill_ff),
         .new_node    (new_node),
         .new_dist    (dist_ff),
         .left_node   (l_node),
         .left_dist   (l_dist),
         .left_exp    (l_exp),
         .left_before (l_before),
         .node        (c_node[i]),
         .distance    (c_dist[i]),
         .exp         (c_exp[i]),
         .valid       (c_valid[i]),
         .ahead       (c_before[i]),
         .cand        (c_cand[i])
      );
   end

   // first unexpanded entry: group flags registered, then priority pick
   assign cand_pad = PAD'(c_cand);
   for (genvar g = 0; g < NGRP; g++) begin : g_grp
      assign grp_any_in[g] = |cand_pad[g*GRP +: GRP];
   end

   always_ff @(posedge clock) begin
      grp_any_ff <= grp_any_in;
   end

   always_comb begin
      logic found_grp;
      logic found_in;
      found_grp = 1'b0;
      take_pad  = '0;
      for (int g = 0; g < NGRP; g++) begin
         grp_first[g] = grp_any_ff[g] && !found_grp;
         found_grp    = found_grp || grp_any_ff[g];
         found_in     = 1'b0;
         for (int j = 0; j < GRP; j++) begin
            take_pad[g*GRP+j] = grp_first[g] && cand_pad[g*GRP+j] && !found_in;
            found_in          = found_in || cand_pad[g*GRP+j];
         end
      end
   end

   assign take_sel = take_pad[LIST_DEPTH-1:0];
   assign any_cand = |grp_any_ff;
   assign out_sel  = (mode_ff == MODE_TAKE) ? take_sel : rd_sel;

   always_comb begin
      sel_node = '0;
      sel_dist = '0;
      sel_exp  = 1'b0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (out_sel[i]) begin
            sel_node = sel_node | c_node[i];
            sel_dist = sel_dist | c_dist[i];
            sel_exp  = sel_exp | c_exp[i];
         end
      end
   end

   // limit, drop and fill
   assign pl_ext     = CMP_BITS'(pool_limit_ff);
   assign fill_ext   = CMP_BITS'(fill_ff);
   assign all_before = &(c_before | ~c_valid);
   assign slot_ok    = CMP_BITS'(slot_ff) < fill_ext;

   always_comb begin
      lim = (pl_ext < CMP_BITS'(POOL_MIN)) ? CMP_BITS'(POOL_MIN) : pl_ext;
      if (lim > CMP_BITS'(LIST_DEPTH)) begin
         lim = CMP_BITS'(LIST_DEPTH);
      end
   end

   assign drop     = (fill_ext >= lim) && all_before;
   assign can_grow = (fill_ext < CMP_BITS'(LIST_DEPTH)) && (fill_ext + 1'b1 <= lim);

   always_comb begin
      fill_in = fill_ff;
      case (mode_ff)
         MODE_CLEAR: fill_in = '0;
         MODE_OFFER: begin
            if (fresh && !drop && can_grow) begin
               fill_in = fill_ff + 1'b1;
            end
         end
         default: fill_in = fill_ff;
      endcase
   end

   assign fill_in_ext = CMP_BITS'(fill_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (exec_fire) begin
         fill_ff <= fill_in;
      end
   end

   // response register
   always_comb begin
      rsp_status_in = STS_OK;
      rsp_node_in   = '0;
      rsp_dist_in   = '0;
      rsp_exp_in    = 1'b0;
      case (mode_ff)
         MODE_CLEAR: rsp_status_in = STS_CLEARED;
         MODE_OFFER: begin
            if (out_range) begin
               rsp_status_in = STS_RANGE;
            end else if (seen) begin
               rsp_status_in = STS_SEEN;
            end else if (drop) begin
               rsp_status_in = STS_DROPPED;
            end
         end
         MODE_TAKE: begin
            if (any_cand) begin
               rsp_node_in = sel_node;
               rsp_dist_in = sel_dist;
               rsp_exp_in  = 1'b1;
            end else begin
               rsp_status_in = STS_NONE;
            end
         end
         MODE_READ: begin
            if (slot_ok) begin
               rsp_node_in = sel_node;
               rsp_dist_in = sel_dist;
               rsp_exp_in  = sel_exp;
            end else begin
               rsp_status_in = STS_EMPTY;
            end
         end
         default: rsp_status_in = STS_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_node_ff   <= rsp_node_in;
         rsp_dist_ff   <= rsp_dist_in;
         rsp_exp_ff    <= rsp_exp_in;
         rsp_count_ff  <= fill_in_ext[7:0];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_result_node     = rsp_node_ff;
   assign rsp_result_distance = rsp_dist_ff;
   assign rsp_result_expanded = rsp_exp_ff;
   assign rsp_entry_count     = rsp_count_ff;

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("response raised outside execute");

   a_fill_from_exec: assert property (@(posedge clock) disable iff (reset)
      !$stable(fill_ff) |-> $past(exec_fire))
      else $error("fill changed without a transaction");

   a_take_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(take_sel))
      else $error("more than one cell selected for take");

   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      (accept && bscp_mode_type'(req_mode) == MODE_CLEAR) |=> (state_ff == S_CLEAR && pend_ff))
      else $error("clear did not start a bitmap sweep");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ext <= CMP_BITS'(LIST_DEPTH))
      else $error("fill beyond list depth");

endmodule
